// ----- src/integer_matrix_column_multiply_assert.svh -----
// ---------------------------------------------------------------------------
// integer_matrix_column_multiply assertion macros
// Concurrent assertion helpers; they expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_COLUMN_MULTIPLY_ASSERT_SVH
`define INTEGER_MATRIX_COLUMN_MULTIPLY_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define IMCM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("imcm assertion failed");
// next-cycle implication
`define IMCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("imcm assertion failed");
`else
`define IMCM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define IMCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/imcm_pkg.sv -----
// ---------------------------------------------------------------------------
// imcm_pkg
// Shared types, constants and helpers of the column multiply block.
// ---------------------------------------------------------------------------
package imcm_pkg;

    // field widths
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 4;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    // sizing defaults
    localparam int DEF_MAX_DIM  = 16;
    localparam int DIM_CAP_HW   = 16;
    localparam int CMD_Q_DEPTH  = 2;
    localparam int RES_Q_DEPTH  = 4;
    localparam int PEND_W       = $clog2(RES_Q_DEPTH + 1);

    // input command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;
    localparam logic [CFG_W-1:0]     CFG_RESET     = 5'd16;

    typedef enum logic [1:0] {
        OP_LOAD_A,
        OP_LOAD_B,
        OP_COMPUTE
    } t_op;

    typedef enum logic {
        BK_IDLE,
        BK_ISSUE
    } t_back_state;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [DATA_W-1:0] element;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
        logic signed [DATA_W-1:0] product_value;
        logic                     last_of_column;
    } t_out_item;

    // classified command between front and back end
    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] element;
    } t_cmd;

    // tag that travels with each multiply-accumulate step
    typedef struct packed {
        logic             first;
        logic             last;
        logic             last_col;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

    typedef struct packed {
        logic              busy;
        logic [PEND_W-1:0] pend;
    } t_back_status;

    // zero acts as one, values above the cap saturate
    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] cap);
        logic [CFG_W-1:0] res;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (v > cap) begin
            res = cap;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ----- src/imcm_fifo.sv -----
// ---------------------------------------------------------------------------
// imcm_fifo
// Small synchronous queue with a registered entry array and fill count.
// ---------------------------------------------------------------------------
module imcm_fifo
    import imcm_pkg::*;
#(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  T                           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output T                           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    T              r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    // handshake qualification
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- src/imcm_front.sv -----
// ---------------------------------------------------------------------------
// imcm_front
// Accepts items, drops those with no effect and registers the rest as
// classified commands for the back end.
// ---------------------------------------------------------------------------
module imcm_front
    import imcm_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  t_in_item         i_item,
    input  logic [CFG_W-1:0] i_cols,
    output logic             o_cmd_vld,
    output t_cmd             o_cmd,
    input  logic             i_q_full
);
    logic r_vld;
    t_cmd r_cmd;
    logic keep;
    logic in_store;
    logic accept;
    t_cmd n_cmd;

    // load must land inside the store
    assign in_store = (32'(i_item.row_index) < 32'(MAX_DIM)) &&
                      (32'(i_item.col_index) < 32'(MAX_DIM));

    // classify the item
    always_comb begin
        n_cmd.row     = i_item.row_index;
        n_cmd.col     = i_item.col_index;
        n_cmd.element = i_item.element;
        n_cmd.op      = OP_COMPUTE;
        keep          = 1'b0;
        unique case (i_item.cmd)
            CMD_LOAD_A: begin
                n_cmd.op = OP_LOAD_A;
                keep     = in_store;
            end
            CMD_LOAD_B: begin
                n_cmd.op = OP_LOAD_B;
                keep     = in_store;
            end
            CMD_COMPUTE: begin
                n_cmd.op = OP_COMPUTE;
                keep     = ({1'b0, i_item.col_index} < i_cols);
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_full    = r_vld & i_q_full;
    assign accept    = i_push & ~o_full;
    assign o_cmd_vld = r_vld;
    assign o_cmd     = r_cmd;

    // holding register in front of the command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= keep;
        end else if (r_vld && !i_q_full) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ----- src/imcm_back.sv -----
// ---------------------------------------------------------------------------
// imcm_back
// Matrix stores and a single pipelined multiply-accumulate unit that walks
// one result column row by row.
// ---------------------------------------------------------------------------
module imcm_back
    import imcm_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CFG_W-1:0]  i_nr,
    input  logic [CFG_W-1:0]  i_nk,
    input  logic              i_q_empty,
    input  t_cmd              i_q_cmd,
    output logic              o_q_pop,
    input  logic [PEND_W-1:0] i_res_count,
    output logic              o_res_push,
    output t_out_item         o_res_item,
    output t_back_status      o_status
);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    t_back_state       r_state;
    t_back_state       n_state;
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_k;
    logic [IDX_W-1:0]  r_col;
    logic [PEND_W-1:0] r_pend;
    logic [DATA_W-1:0] r_mem_a [DEPTH];
    logic [DATA_W-1:0] r_mem_b [DEPTH];
    logic [DATA_W-1:0] r_a_rd;
    logic [DATA_W-1:0] r_b_rd;
    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_acc;
    logic              r_v1;
    logic              r_v2;
    t_tag              r_t1;
    t_tag              r_t2;

    logic              credit;
    logic              issue;
    logic              start;
    logic              wr_a;
    logic              wr_b;
    logic              k_last;
    logic              row_last;
    logic [AW-1:0]     ld_addr;
    logic [AW-1:0]     rd_a_addr;
    logic [AW-1:0]     rd_b_addr;
    logic [DATA_W-1:0] acc_next;
    t_tag              tag;

    // room in the result queue for every row already started and one more
    assign credit   = ((PEND_W + 1)'(i_res_count) + (PEND_W + 1)'(r_pend)) <
                      (PEND_W + 1)'(RES_Q_DEPTH);
    assign k_last   = ({1'b0, r_k} == i_nk - 1'b1);
    assign row_last = ({1'b0, r_row} == i_nr - 1'b1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty && i_q_cmd.op == OP_COMPUTE) begin
                    n_state = BK_ISSUE;
                end
            end
            BK_ISSUE: begin
                if (issue && k_last && row_last) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop = 1'b0;
        issue   = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_q_pop = ~i_q_empty;
            end
            BK_ISSUE: begin
                issue = (r_k != '0) | credit;
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    assign wr_a  = o_q_pop & (i_q_cmd.op == OP_LOAD_A);
    assign wr_b  = o_q_pop & (i_q_cmd.op == OP_LOAD_B);
    assign start = o_q_pop & (i_q_cmd.op == OP_COMPUTE);

    // store addresses, row-major
    assign ld_addr   = AW'(i_q_cmd.row) * AW'(MAX_DIM) + AW'(i_q_cmd.col);
    assign rd_a_addr = AW'(r_row) * AW'(MAX_DIM) + AW'(r_k);
    assign rd_b_addr = AW'(r_k) * AW'(MAX_DIM) + AW'(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // row and inner counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_k   <= '0;
        end else if (start) begin
            r_row <= '0;
            r_k   <= '0;
        end else if (issue) begin
            if (k_last) begin
                r_k   <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_col <= i_q_cmd.col;
        end
    end

    // matrix A store
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_mem_a[ld_addr] <= i_q_cmd.element;
        end
        if (issue) begin
            r_a_rd <= r_mem_a[rd_a_addr];
        end
    end

    // matrix B store
    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            r_mem_b[ld_addr] <= i_q_cmd.element;
        end
        if (issue) begin
            r_b_rd <= r_mem_b[rd_b_addr];
        end
    end

    // step tag
    always_comb begin
        tag.first    = (r_k == '0);
        tag.last     = k_last;
        tag.last_col = row_last;
        tag.row      = r_row;
        tag.col      = r_col;
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
        end
    end

    // multiply, low word only since sums wrap
    always_ff @(posedge i_clk) begin
        r_t1 <= tag;
        r_t2 <= r_t1;
        if (r_v1) begin
            r_prod <= r_a_rd * r_b_rd;
        end
    end

    // accumulate
    assign acc_next = r_t2.first ? r_prod : r_acc + r_prod;

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_acc <= acc_next;
        end
    end

    assign o_res_push                = r_v2 & r_t2.last;
    assign o_res_item.out_row        = r_t2.row;
    assign o_res_item.out_col        = r_t2.col;
    assign o_res_item.product_value  = acc_next;
    assign o_res_item.last_of_column = r_t2.last_col;

    // rows started but not yet in the result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            priority if (issue && r_k == '0 && !o_res_push) begin
                r_pend <= r_pend + 1'b1;
            end else if (o_res_push && !(issue && r_k == '0)) begin
                r_pend <= r_pend - 1'b1;
            end
        end
    end

    assign o_status.busy = (r_state != BK_IDLE) | r_v1 | r_v2;
    assign o_status.pend = r_pend;

endmodule

// ----- src/integer_matrix_column_multiply.sv -----
// ---------------------------------------------------------------------------
// integer_matrix_column_multiply
// Signed 32-bit matrix store with one result column of A times B per request.
// ---------------------------------------------------------------------------
// Usage: items enter on push/full with i_in_item (load A element, load B
// element, or compute a column); results leave on empty/pop with o_out_item,
// one per row of A, the last of a column flagged.
// Configuration (rows_a, inner_len, cols_b) is written on i_cfg_valid with
// i_cfg_index/i_cfg_data; o_cfg_ready is always high. Write only while idle.
// A load passes the front holding register and the command queue and is
// written to its store when the idle back end pops it. A compute item is
// popped likewise; the back end then walks the column with the single
// multiply-accumulate unit reading one A and one B word per cycle from the
// two stores, pausing before a row while the result queue lacks room, and
// takes the next command once the last step of the column has issued.
// A command queue decouples the front end, so items keep being accepted
// while a column is computed, until that queue fills.
// When the receiver stalls, the result queue fills, the back end holds before
// starting another row, and full rises once the command queue is full too.
// Reset clears queues and control and sets all dimensions to 16; store
// contents are undefined until written.
// ---------------------------------------------------------------------------
`include "integer_matrix_column_multiply_assert.svh"

module integer_matrix_column_multiply
    import imcm_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_in_item             i_in_item,
    output logic                 empty,
    input  logic                 pop,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    localparam int DIM_CAP = (MAX_DIM < DIM_CAP_HW) ? MAX_DIM : DIM_CAP_HW;

    logic [CFG_W-1:0]  r_rows_a;
    logic [CFG_W-1:0]  r_inner_len;
    logic [CFG_W-1:0]  r_cols_b;
    logic [CFG_W-1:0]  nr;
    logic [CFG_W-1:0]  nk;
    logic [CFG_W-1:0]  nc;

    logic              front_vld;
    t_cmd              front_cmd;
    logic              cmd_push;
    logic              cmd_full;
    logic              cmd_empty;
    logic              cmd_pop;
    t_cmd              cmd_head;
    logic [$clog2(CMD_Q_DEPTH+1)-1:0] cmd_count;

    logic              res_push;
    logic              res_full;
    t_out_item         res_item;
    logic [PEND_W-1:0] res_count;
    t_back_status      back_status;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= CFG_RESET;
            r_inner_len <= CFG_RESET;
            r_cols_b    <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROWS_A:    r_rows_a    <= i_cfg_data;
                REG_INNER_LEN: r_inner_len <= i_cfg_data;
                REG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // effective dimensions
    assign nr = eff_dim(r_rows_a, CFG_W'(DIM_CAP));
    assign nk = eff_dim(r_inner_len, CFG_W'(DIM_CAP));
    assign nc = eff_dim(r_cols_b, CFG_W'(DIM_CAP));

    imcm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_item    (i_in_item),
        .i_cols    (nc),
        .o_cmd_vld (front_vld),
        .o_cmd     (front_cmd),
        .i_q_full  (cmd_full)
    );

    assign cmd_push = front_vld & ~cmd_full;

    imcm_fifo #(
        .T     (t_cmd),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_empty (cmd_empty),
        .o_count (cmd_count)
    );

    imcm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nr        (nr),
        .i_nk        (nk),
        .i_q_empty   (cmd_empty),
        .i_q_cmd     (cmd_head),
        .o_q_pop     (cmd_pop),
        .i_res_count (res_count),
        .o_res_push  (res_push),
        .o_res_item  (res_item),
        .o_status    (back_status)
    );

    imcm_fifo #(
        .T     (t_out_item),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_item),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_out_item),
        .o_empty (empty),
        .o_count (res_count)
    );

    // result queue is never pushed without room
    `IMCM_ASSERT_IMPL(a_res_no_overflow, i_clk, i_rst_n, res_push, !res_full)
    // started rows never exceed result queue space
    `IMCM_ASSERT_IMPL(a_credit_bound, i_clk, i_rst_n, 1'b1,
        ((PEND_W + 1)'(res_count) + (PEND_W + 1)'(back_status.pend)) <=
        (PEND_W + 1)'(RES_Q_DEPTH))
    // the flagged result belongs to the last row
    `IMCM_ASSERT_IMPL(a_last_row, i_clk, i_rst_n, res_push && res_item.last_of_column,
        res_item.out_row == IDX_W'(nr - 1'b1))
    // a single waiting item taken with nothing arriving leaves the queue empty
    `IMCM_ASSERT_NEXT(a_drain, i_clk, i_rst_n,
        pop && !empty && res_count == PEND_W'(1) && !res_push, empty)

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for integer_matrix_column_multiply
// Loads both matrix stores, sweeps the dimension registers and requests result
// columns; a predictor keeps its own copy of the stores and sizes and checks
// every result item in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import imcm_pkg::*;

    localparam int STORE_DIM    = DEF_MAX_DIM;
    localparam int SIZE_LIMIT   = (DEF_MAX_DIM < 16) ? DEF_MAX_DIM : 16;
    localparam int DRAIN_CYCLES = 24;

    // codes the block has no name for
    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    t_in_item             i_in_item;
    logic                 empty;
    logic                 pop;
    t_out_item            o_out_item;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    // predictor copy of the stores and the dimension registers
    logic [DATA_W-1:0] a_words [STORE_DIM][STORE_DIM];
    logic [DATA_W-1:0] b_words [STORE_DIM][STORE_DIM];
    bit                a_loaded [STORE_DIM][STORE_DIM];
    bit                b_loaded [STORE_DIM][STORE_DIM];
    logic [CFG_W-1:0]  rows_reg;
    logic [CFG_W-1:0]  inner_reg;
    logic [CFG_W-1:0]  cols_reg;

    t_out_item pending_products[$];
    int        error_count = 0;
    bit        idling_on   = 1'b1;

    integer_matrix_column_multiply uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // zero acts as one, larger values clamp to the limit
    function automatic int unsigned active_size(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (v > SIZE_LIMIT) begin
            return SIZE_LIMIT;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // register write as the block sees it
    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] data);
        case (idx)
            REG_ROWS_A:    rows_reg = data;
            REG_INNER_LEN: inner_reg = data;
            REG_COLS_B:    cols_reg = data;
            default: ;
        endcase
    endfunction

    // update the stores or queue the products of one accepted item
    function automatic void apply_item(input t_in_item req);
        int unsigned       nr;
        int unsigned       nk;
        int unsigned       nc;
        int unsigned       col;
        logic [DATA_W-1:0] acc;
        t_out_item         res;
        nr  = active_size(rows_reg);
        nk  = active_size(inner_reg);
        nc  = active_size(cols_reg);
        col = req.col_index;
        case (req.cmd)
            CMD_LOAD_A: begin
                if (req.row_index < STORE_DIM && req.col_index < STORE_DIM) begin
                    a_words[req.row_index][req.col_index]  = req.element;
                    a_loaded[req.row_index][req.col_index] = 1'b1;
                end
            end
            CMD_LOAD_B: begin
                if (req.row_index < STORE_DIM && req.col_index < STORE_DIM) begin
                    b_words[req.row_index][req.col_index]  = req.element;
                    b_loaded[req.row_index][req.col_index] = 1'b1;
                end
            end
            CMD_COMPUTE: begin
                if (col < nc) begin
                    for (int r = 0; r < nr; r++) begin
                        acc = '0;
                        for (int k = 0; k < nk; k++) begin
                            acc = acc + a_words[r][k] * b_words[k][col];
                        end
                        res.out_row        = IDX_W'(r);
                        res.out_col        = req.col_index;
                        res.product_value  = acc;
                        res.last_of_column = (r + 1 == nr);
                        pending_products.push_back(res);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // mostly full-range values, with the extremes showing up often
    function automatic logic [DATA_W-1:0] pick_element();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '1;
            3:       return '0;
            4:       return DATA_W'(int'($urandom_range(0, 200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    // small sizes keep the store loads short; zero shows up now and then
    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return '0;
            default: return CFG_W'($urandom_range(1, 5));
        endcase
    endfunction

    // send one item; returns at the falling edge after it was taken
    task automatic send_item(input t_in_item req);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= req;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        apply_item(req);
        @(negedge i_clk);
    endtask

    task automatic send_fields(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                               input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] elem);
        t_in_item req;
        req.cmd       = cmd;
        req.row_index = row;
        req.col_index = col;
        req.element   = elem;
        send_item(req);
    endtask

    // load every entry the column still needs, then request it
    task automatic compute_column(input int unsigned col);
        int unsigned nr;
        int unsigned nk;
        int unsigned nc;
        nr = active_size(rows_reg);
        nk = active_size(inner_reg);
        nc = active_size(cols_reg);
        if (col < nc) begin
            for (int r = 0; r < nr; r++) begin
                for (int k = 0; k < nk; k++) begin
                    if (!a_loaded[r][k]) begin
                        send_fields(CMD_LOAD_A, IDX_W'(r), IDX_W'(k), pick_element());
                    end
                end
            end
            for (int k = 0; k < nk; k++) begin
                if (!b_loaded[k][col]) begin
                    send_fields(CMD_LOAD_B, IDX_W'(k), IDX_W'(col), pick_element());
                end
            end
        end
        send_fields(CMD_COMPUTE, IDX_W'($urandom_range(0, 15)), IDX_W'(col), $urandom);
    endtask

    // stop sending and let every pending result and store write finish
    task automatic drain_pipeline();
        push <= 1'b0;
        while (pending_products.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // valid stays high when another write follows right away
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                             input bit hold);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        apply_config(idx, data);
        @(negedge i_clk);
        if (!hold) begin
            i_cfg_valid <= 1'b0;
        end
    endtask

    task automatic configure(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
                             input logic [CFG_W-1:0] cols);
        drain_pipeline();
        write_reg(REG_ROWS_A, rows, 1'b1);
        write_reg(REG_INNER_LEN, inner, 1'b1);
        write_reg(REG_COLS_B, cols, 1'b0);
    endtask

    // one setting of the sizes with a random mix of loads and column requests
    task automatic run_random_phase(input int n_items);
        int unsigned nr;
        int unsigned nk;
        int unsigned nc;
        int unsigned sel;
        configure(pick_dim(), pick_dim(), pick_dim());
        nr = active_size(rows_reg);
        nk = active_size(inner_reg);
        nc = active_size(cols_reg);
        for (int i = 0; i < n_items; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                if ($urandom_range(0, 7) == 0) begin
                    compute_column($urandom_range(0, 15));
                end else begin
                    compute_column($urandom_range(0, nc - 1));
                end
            end else if (sel < 62) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_fields(CMD_LOAD_A, IDX_W'($urandom), IDX_W'($urandom),
                                pick_element());
                end else begin
                    send_fields(CMD_LOAD_A, IDX_W'($urandom_range(0, nr - 1)),
                                IDX_W'($urandom_range(0, nk - 1)), pick_element());
                end
            end else if (sel < 85) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_fields(CMD_LOAD_B, IDX_W'($urandom), IDX_W'($urandom),
                                pick_element());
                end else begin
                    send_fields(CMD_LOAD_B, IDX_W'($urandom_range(0, nk - 1)),
                                IDX_W'($urandom_range(0, nc - 1)), pick_element());
                end
            end else begin
                send_fields(CMD_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
            end
        end
    endtask

    // 2x2 product with wrapping values, ignored fields and out-of-range columns
    task automatic test_directed_corners();
        configure(5'd2, 5'd2, 5'd2);
        send_fields(CMD_LOAD_A, 4'd0, 4'd0, 32'h8000_0000);
        send_fields(CMD_LOAD_A, 4'd0, 4'd1, 32'h7fff_ffff);
        send_fields(CMD_LOAD_A, 4'd1, 4'd0, 32'hffff_ffff);
        send_fields(CMD_LOAD_A, 4'd1, 4'd1, 32'h0000_0001);
        send_fields(CMD_LOAD_B, 4'd0, 4'd0, 32'h7fff_ffff);
        send_fields(CMD_LOAD_B, 4'd1, 4'd0, 32'h8000_0000);
        send_fields(CMD_LOAD_B, 4'd0, 4'd1, 32'hffff_ffff);
        send_fields(CMD_LOAD_B, 4'd1, 4'd1, 32'h0000_0000);
        // beyond the configured size, still stored
        send_fields(CMD_LOAD_A, 4'd15, 4'd15, 32'h7fff_ffff);
        send_fields(CMD_LOAD_B, 4'd15, 4'd15, 32'h8000_0000);
        send_fields(CMD_UNUSED, 4'd15, 4'd15, 32'hffff_ffff);
        send_fields(CMD_COMPUTE, 4'd15, 4'd0, 32'hffff_ffff);
        send_fields(CMD_COMPUTE, 4'd0, 4'd1, 32'h0000_0000);
        send_fields(CMD_COMPUTE, 4'd0, 4'd2, 32'h0000_0000);
        send_fields(CMD_COMPUTE, 4'd9, 4'd15, 32'h1234_5678);
        // unknown register leaves the sizes alone
        drain_pipeline();
        write_reg(REG_UNUSED, 5'h1f, 1'b0);
        send_fields(CMD_COMPUTE, 4'd3, 4'd1, 32'h0000_0000);
    endtask

    // zero, oversized and exact-limit sizes
    task automatic test_dimension_extremes();
        configure(5'd0, 5'd0, 5'd0);
        compute_column(0);
        compute_column(1);
        configure(5'd31, 5'd1, 5'd20);
        compute_column(15);
        compute_column(0);
        compute_column($urandom_range(1, 14));
        configure(5'd1, 5'd17, 5'd16);
        compute_column(15);
        configure(5'd16, 5'd1, 5'd16);
        compute_column($urandom_range(0, 15));
        compute_column(15);
        configure(5'd1, 5'd16, 5'd1);
        compute_column(0);
        compute_column(1);
    endtask

    task automatic test_random_traffic();
        idling_on = 1'b1;
        repeat (4) run_random_phase(19);
    endtask

    // final stretch at full rate on both sides
    task automatic test_closing_traffic();
        drain_pipeline();
        idling_on = 1'b0;
        run_random_phase(24);
    endtask

    // result side: random stall bursts on pop
    initial begin
        pop <= 1'b0;
        @(negedge i_clk);
        forever begin
            if (idling_on && $urandom_range(0, 4) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            pop <= 1'b1;
            @(negedge i_clk);
        end
    end

    // compare each accepted result item with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (pending_products.size() == 0) begin
                report_mismatch($sformatf("unexpected result row %0d col %0d",
                                          o_out_item.out_row, o_out_item.out_col));
            end else begin
                want = pending_products.pop_front();
                if (o_out_item.out_row !== want.out_row) begin
                    report_mismatch($sformatf("out_row %0d, expected %0d",
                                              o_out_item.out_row, want.out_row));
                end
                if (o_out_item.out_col !== want.out_col) begin
                    report_mismatch($sformatf("out_col %0d, expected %0d",
                                              o_out_item.out_col, want.out_col));
                end
                if (o_out_item.product_value !== want.product_value) begin
                    report_mismatch($sformatf("product_value %0d, expected %0d (row %0d)",
                                              o_out_item.product_value,
                                              want.product_value, want.out_row));
                end
                if (o_out_item.last_of_column !== want.last_of_column) begin
                    report_mismatch($sformatf("last_of_column %0b, expected %0b (row %0d)",
                                              o_out_item.last_of_column,
                                              want.last_of_column, want.out_row));
                end
            end
        end
    end

    // main sequence
    initial begin
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        rows_reg  = CFG_RESET;
        inner_reg = CFG_RESET;
        cols_reg  = CFG_RESET;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_corners();
        test_dimension_extremes();
        test_random_traffic();
        test_closing_traffic();
        drain_pipeline();

        if (pending_products.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_products.size()));
        end
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/imcm_pkg.sv
src/imcm_fifo.sv
src/imcm_front.sv
src/imcm_back.sv
src/integer_matrix_column_multiply.sv
sim/testbench.sv
